FILE: src/tlpt_pkg.sv
// Shared constants and types for the two-level page table unit.
`default_nettype none
package tlpt_pkg;

  localparam int DEF_ENTRIES   = 16;
  localparam int DEF_PROCESSES = 4;

  localparam int ADDR_W    = 32;
  localparam int PROC_W    = 2;
  localparam int IDX_W     = 10;   // directory / entry field width in a virtual address
  localparam int DIR_LSB   = 22;
  localparam int ENT_LSB   = 12;

  typedef enum logic {
    OP_ALLOC     = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  // Lookup decision handed from the fill tracker to the pipeline.
  typedef struct packed {
    logic              ok;      // item succeeds
    logic              is_tr;   // translate item
    logic              rd_en;   // read slot address from table
    logic              wr_en;   // store phys address into table
    logic [ADDR_W-1:0] va;      // virtual address returned on allocate
  } dec_t;

endpackage
`default_nettype wire

FILE: src/tlpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/tlpt_fill.sv
// Per-process fill pointers and the allocate / translate decision.
`default_nettype none
module tlpt_fill #(
  parameter int ENTRIES   = tlpt_pkg::DEF_ENTRIES,
  parameter int PROCESSES = tlpt_pkg::DEF_PROCESSES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic                         op,
  input  wire logic [tlpt_pkg::PROC_W-1:0]  process,
  input  wire logic [tlpt_pkg::ADDR_W-1:0]  vaddr,
  output tlpt_pkg::dec_t                    dec,
  output logic [((PROCESSES < (1 << tlpt_pkg::PROC_W)) ? PROCESSES
                 : (1 << tlpt_pkg::PROC_W)) > 1
                ? $clog2((PROCESSES < (1 << tlpt_pkg::PROC_W)) ? PROCESSES
                         : (1 << tlpt_pkg::PROC_W)) + 2 * $clog2(ENTRIES) - 1
                : 2 * $clog2(ENTRIES) : 0] addr
);

  // Only processes reachable through the process field get a table.
  localparam int NPROC = (PROCESSES < (1 << tlpt_pkg::PROC_W)) ? PROCESSES
                         : (1 << tlpt_pkg::PROC_W);
  localparam int PW    = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int IW    = $clog2(ENTRIES);
  localparam int DW    = $clog2(ENTRIES + 1);

  // Slots fill strictly in order and are never freed, so a (dir, entry)
  // pointer per process marks exactly the valid slots.
  logic [DW-1:0] dir_cnt_r [NPROC];
  logic [IW-1:0] ent_cnt_r [NPROC];
  logic [DW-1:0] dir_nxt;
  logic [IW-1:0] ent_nxt;

  logic                   proc_ok;
  logic [PW-1:0]          pi;
  logic [DW-1:0]          cur_dir;
  logic [IW-1:0]          cur_ent;
  logic                   full;
  logic [tlpt_pkg::IDX_W-1:0] va_dir;
  logic [tlpt_pkg::IDX_W-1:0] va_ent;
  logic                   range_ok;
  logic [DW-1:0]          tr_dir;
  logic                   in_use;
  logic                   is_tr;
  logic                   bump;

  always_comb begin
    proc_ok  = {30'd0, process} < 32'(NPROC);
    pi       = process[PW-1:0];
    cur_dir  = dir_cnt_r[pi];
    cur_ent  = ent_cnt_r[pi];
    full     = cur_dir == DW'(ENTRIES);
    is_tr    = op == tlpt_pkg::OP_TRANSLATE;

    va_dir   = vaddr[tlpt_pkg::DIR_LSB +: tlpt_pkg::IDX_W];
    va_ent   = vaddr[tlpt_pkg::ENT_LSB +: tlpt_pkg::IDX_W];
    range_ok = ({1'b0, va_dir} < 11'(ENTRIES)) && ({1'b0, va_ent} < 11'(ENTRIES));
    tr_dir   = DW'(va_dir[IW-1:0]);
    in_use   = (tr_dir < cur_dir) ||
               ((tr_dir == cur_dir) && (va_ent[IW-1:0] < cur_ent));

    bump      = accept && !is_tr && proc_ok && !full;

    dec.is_tr = is_tr;
    dec.ok    = proc_ok && (is_tr ? (range_ok && in_use) : !full);
    dec.rd_en = accept && is_tr && proc_ok && range_ok && in_use;
    dec.wr_en = bump;
    dec.va    = (tlpt_pkg::ADDR_W'(cur_dir) << tlpt_pkg::DIR_LSB) |
                (tlpt_pkg::ADDR_W'(cur_ent) << tlpt_pkg::ENT_LSB);

    if (is_tr) begin
      addr = {pi, va_dir[IW-1:0], va_ent[IW-1:0]};
    end else begin
      addr = {pi, cur_dir[IW-1:0], cur_ent};
    end

    // advance pointer: next entry, wrap into next directory
    if (cur_ent == IW'(ENTRIES - 1)) begin
      ent_nxt = '0;
      dir_nxt = cur_dir + DW'(1);
    end else begin
      ent_nxt = cur_ent + IW'(1);
      dir_nxt = cur_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NPROC; p++) begin
        dir_cnt_r[p] <= '0;
        ent_cnt_r[p] <= '0;
      end
    end else if (bump) begin
      dir_cnt_r[pi] <= dir_nxt;
      ent_cnt_r[pi] <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/two_level_page_table_alloc_translate_unit.sv
// Top level: two-level page table with slot allocation and translation.
//
// Usage:
// - Input channel (in_valid / in_stall): one item per op. in_op selects
//   allocate (store in_phys_addr in the first free slot of in_process) or
//   translate (look up in_vaddr, dir = bits 31:22, entry = bits 21:12).
// - Result channel (out_valid / out_stall): one item per input item, in
//   order. out_status 0 = ok; 1 = table full, fault, or bad process, with
//   out_value forced to zero.
// - Pipeline: the decision and table read are registered into the middle
//   stage on accept, and the result register behind it drives out_valid.
// - Throughput: one item per cycle unless stalled by out_stall; the RAM
//   takes one write or one read per accepted item, and the per-process
//   fill pointers update in the accept cycle so the next item sees them.
// - Reset (rst_n low, synchronous): all tables become empty (fill pointers
//   cleared) and both pipeline stages drain. The table RAM is not cleared;
//   only slots below the fill pointer are ever read.
// - Stall: when out_stall holds a result, the middle stage fills and then
//   in_stall rises; no item is dropped or repeated.
`default_nettype none
module two_level_page_table_alloc_translate_unit #(
  parameter int ENTRIES   = tlpt_pkg::DEF_ENTRIES,
  parameter int PROCESSES = tlpt_pkg::DEF_PROCESSES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_op,
  input  wire logic [tlpt_pkg::PROC_W-1:0] in_process,
  input  wire logic [tlpt_pkg::ADDR_W-1:0] in_phys_addr,
  input  wire logic [tlpt_pkg::ADDR_W-1:0] in_vaddr,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_status,
  output logic      [tlpt_pkg::ADDR_W-1:0] out_value
);

  localparam int NPROC = (PROCESSES < (1 << tlpt_pkg::PROC_W)) ? PROCESSES
                         : (1 << tlpt_pkg::PROC_W);
  localparam int PW    = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int IW    = $clog2(ENTRIES);
  localparam int AW    = PW + 2 * IW;       // table address: {process, dir, entry}
  localparam int DEPTH = 1 << AW;

  logic                        accept;
  tlpt_pkg::dec_t              dec;
  logic [AW-1:0]               addr;
  logic [tlpt_pkg::ADDR_W-1:0] rd_data;

  // middle stage
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_ok_r;
  logic                        s1_tr_r;
  logic [tlpt_pkg::ADDR_W-1:0] s1_va_r;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_status_r;
  logic [tlpt_pkg::ADDR_W-1:0] out_value_r;

  logic out_free;
  logic s1_move;

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_move       = s1_valid_r && out_free;
    in_stall      = s1_valid_r && !out_free;
    accept        = in_valid && !in_stall;
    s1_valid_nxt  = accept || (s1_valid_r && !out_free);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
  end

  tlpt_fill #(
    .ENTRIES  (ENTRIES),
    .PROCESSES(PROCESSES)
  ) u_fill (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (in_op),
    .process  (in_process),
    .vaddr    (in_vaddr),
    .dec      (dec),
    .addr     (addr)
  );

  // Read data is held until the next read, which only happens on accept,
  // so it stays aligned with the middle stage while that stage is stalled.
  tlpt_ram #(
    .WIDTH(tlpt_pkg::ADDR_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (dec.wr_en),
    .waddr(addr),
    .wdata(in_phys_addr),
    .re   (dec.rd_en),
    .raddr(addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r <= dec.ok;
      s1_tr_r <= dec.is_tr;
      s1_va_r <= dec.va;
    end
    if (s1_move) begin
      out_status_r <= !s1_ok_r;
      if (!s1_ok_r) begin
        out_value_r <= '0;
      end else if (s1_tr_r) begin
        out_value_r <= rd_data;
      end else begin
        out_value_r <= s1_va_r;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule
`default_nettype wire
